// File: src/wpsp_pkg.sv
package wpsp_pkg;

   localparam int HEADER_BYTES = 44;

   // byte positions inside the fixed header (position of the last byte of each field)
   localparam logic [5:0] POS_RIFF  = 6'd3;
   localparam logic [5:0] POS_WAVE  = 6'd11;
   localparam logic [5:0] POS_FMT   = 6'd15;
   localparam logic [5:0] POS_CHAN  = 6'd23;
   localparam logic [5:0] POS_RATE  = 6'd27;
   localparam logic [5:0] POS_DEPTH = 6'd35;
   localparam logic [5:0] POS_DATA  = 6'd39;
   localparam logic [5:0] POS_LAST  = 6'(HEADER_BYTES - 1);

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [30:0] FRAME_MAX = 31'h7FFF_FFFF;

   localparam int         DIV_STEPS = 32;
   localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);

   localparam logic CSR_LIMIT_ENABLE = 1'b0;
   localparam logic CSR_SAMPLE_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } item_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_RIFF   = 3'd1,
      ERR_WAVE   = 3'd2,
      ERR_FMT    = 3'd3,
      ERR_DATA   = 3'd4,
      ERR_FORMAT = 3'd5
   } error_type;

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_DIVIDE,
      ST_SAMPLES,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       clear;
      logic       hdr;
      logic       smp;
      logic [5:0] pos;
      logic       div_start;
   } cmd_type;

   typedef struct packed {
      error_type tag_err;
      logic      fmt_bad;
      logic      last;
      logic      div_done;
      logic      frames_zero;
   } status_type;

   typedef struct packed {
      item_kind_type kind;
      logic [31:0]   value;
      logic [15:0]   channel;
      logic [30:0]   frame;
      logic          last;
      logic [15:0]   channels;
      logic [31:0]   rate;
      logic [15:0]   depth;
      error_type     err;
   } rsp_type;

   function automatic logic depth_ok(input logic [15:0] d);
      return (d == 16'd8) || (d == 16'd16) || (d == 16'd24) || (d == 16'd32);
   endfunction

endpackage

// File: src/wpsp_if.sv
interface wpsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       file_start;

   modport source (output valid, output file_byte, output file_start, input ready);
   modport sink (input valid, input file_byte, input file_start, output ready);
endinterface

interface wpsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         item_kind;
   logic signed [31:0] sample_value;
   logic [15:0]        channel_index;
   logic [30:0]        frame_index;
   logic               last_sample;
   logic [15:0]        channels_found;
   logic [31:0]        rate_found;
   logic [15:0]        depth_found;
   logic [2:0]         error_code;

   modport source (output valid, output item_kind, output sample_value,
                   output channel_index, output frame_index, output last_sample,
                   output channels_found, output rate_found, output depth_found,
                   output error_code, input ready);
   modport sink (input valid, input item_kind, input sample_value,
                 input channel_index, input frame_index, input last_sample,
                 input channels_found, input rate_found, input depth_found,
                 input error_code, output ready);
endinterface

// File: src/wav_pcm_stream_parser_top.sv
// WAV PCM stream parser. Feed the file one byte per req transfer, with file_start set on
// byte 0 of each file. The 44-byte header is checked (RIFF, WAVE, 'fmt ', 'data' tags)
// and one header item is returned on its last byte: accepted, or rejected with an error
// code; a tag mismatch rejects on the fourth byte of the tag. After an accepted header,
// each complete little-endian sample gives one sample item with its channel and frame
// index; 8-bit data is offset binary, wider data is sign-extended. Rate: one byte per
// cycle, except right after the last header byte, where the input stalls while a
// radix-2 divider works out data_size / (bytes per sample * channels), one quotient bit
// per cycle (with limit_enable set, sample_limit is taken as the frame count instead).
// Results go through a two-entry output queue, so bytes keep flowing while one result
// waits; the queue stalls the input only when both entries are full. Frame count
// and limit are latched per file; csr writes should be made between files.
module wav_pcm_stream_parser_top (
   input  logic        clock,
   input  logic        reset,
   wpsp_req_if.sink    req_bus,
   wpsp_rsp_if.source  rsp_bus,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [30:0] csr_write_data
);

   logic                 limit_enable_ff;
   logic [30:0]          sample_limit_ff;
   logic                 req_accept;
   logic                 hold;
   logic                 q_space;
   logic                 res_valid;
   wpsp_pkg::rsp_type    res;
   wpsp_pkg::cmd_type    cmd;
   wpsp_pkg::status_type st;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         sample_limit_ff <= 31'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wpsp_pkg::CSR_LIMIT_ENABLE: limit_enable_ff <= csr_write_data[0];
            wpsp_pkg::CSR_SAMPLE_LIMIT: sample_limit_ff <= csr_write_data;
         endcase
      end
   end

   // take a byte unless the divider is running or the queue has no room for a result
   assign req_bus.ready = !hold && q_space;
   assign req_accept    = req_bus.valid && req_bus.ready;

   wpsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .file_start (req_bus.file_start),
      .st         (st),
      .cmd        (cmd),
      .hold       (hold)
   );

   wpsp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .file_byte    (req_bus.file_byte),
      .limit_enable (limit_enable_ff),
      .sample_limit (sample_limit_ff),
      .st           (st),
      .res_valid    (res_valid),
      .res          (res)
   );

   wpsp_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (q_space),
      .rsp_bus   (rsp_bus)
   );

   // non-reject items carry no error code
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.item_kind != 2'(wpsp_pkg::KIND_REJECT)))
      |-> (rsp_bus.error_code == 3'(wpsp_pkg::ERR_NONE)))
      else $error("error code on a sample or accepted header");

   // a reject always says why
   a_reject_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.item_kind == 2'(wpsp_pkg::KIND_REJECT)))
      |-> (rsp_bus.error_code != 3'(wpsp_pkg::ERR_NONE)))
      else $error("rejected header without an error code");

   a_last_is_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.last_sample)
      |-> (rsp_bus.item_kind == 2'(wpsp_pkg::KIND_SAMPLE)))
      else $error("last flag on a header item");

   // a result is only produced when the queue can hold it
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> q_space)
      else $error("result produced with the output queue full");

   // the divider stall only starts right after an accepted byte
   a_hold_start: assert property (@(posedge clock) disable iff (reset)
      $rose(hold) |-> $past(req_accept))
      else $error("divider stall without a header transfer");

endmodule

// File: src/wpsp_ctrl.sv
module wpsp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_accept,
   input  logic                  file_start,
   input  wpsp_pkg::status_type  st,
   output wpsp_pkg::cmd_type     cmd,
   output logic                  hold
);

   wpsp_pkg::ctrl_state_type state_ff, state_in, eff_state;
   logic [5:0]               pos_ff, pos_in, pos_eff;

   // file_start restarts parsing on the byte it arrives with
   always_comb begin
      eff_state = file_start ? wpsp_pkg::ST_HEADER : state_ff;
      pos_eff   = file_start ? 6'd0 : pos_ff;
   end

   // outputs
   always_comb begin
      cmd.clear     = req_accept && file_start;
      cmd.hdr       = req_accept && (eff_state == wpsp_pkg::ST_HEADER);
      cmd.smp       = req_accept && (eff_state == wpsp_pkg::ST_SAMPLES);
      cmd.pos       = pos_eff;
      cmd.div_start = cmd.hdr && (pos_eff == wpsp_pkg::POS_LAST) &&
                      (st.tag_err == wpsp_pkg::ERR_NONE) && !st.fmt_bad;
      hold          = (state_ff == wpsp_pkg::ST_DIVIDE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      priority if (cmd.hdr) begin
         priority if (st.tag_err != wpsp_pkg::ERR_NONE) begin
            state_in = wpsp_pkg::ST_DONE;
         end else if (pos_eff == wpsp_pkg::POS_LAST) begin
            state_in = cmd.div_start ? wpsp_pkg::ST_DIVIDE : wpsp_pkg::ST_DONE;
         end else begin
            state_in = wpsp_pkg::ST_HEADER;
            pos_in   = pos_eff + 6'd1;
         end
      end else if (cmd.smp && st.last) begin
         state_in = wpsp_pkg::ST_DONE;
      end else if ((state_ff == wpsp_pkg::ST_DIVIDE) && st.div_done) begin
         state_in = st.frames_zero ? wpsp_pkg::ST_DONE : wpsp_pkg::ST_SAMPLES;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpsp_pkg::ST_HEADER;
         pos_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: src/wpsp_datapath.sv
module wpsp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  wpsp_pkg::cmd_type    cmd,
   input  logic [7:0]           file_byte,
   input  logic                 limit_enable,
   input  logic [30:0]          sample_limit,
   output wpsp_pkg::status_type st,
   output logic                 res_valid,
   output wpsp_pkg::rsp_type    res
);

   logic [31:0] asm_ff;
   logic [15:0] chan_ff;
   logic [31:0] rate_ff;
   logic [15:0] depth_ff;
   logic [30:0] frame_total_ff;
   logic [1:0]  bis_ff;
   logic [15:0] ch_cnt_ff;
   logic [30:0] fr_cnt_ff;

   // frame count divider, one quotient bit per cycle
   logic        div_busy_ff;
   logic        div_done_ff;
   logic [4:0]  div_cnt_ff;
   logic [17:0] div_rem_ff;
   logic [31:0] div_q_ff;
   logic [17:0] div_dvsr_ff;

   logic [31:0]         asm_eff;
   logic [31:0]         hdr_word;
   wpsp_pkg::error_type tag_err;
   logic                fmt_bad;
   logic [2:0]          nbytes;
   logic [17:0]         frame_bytes;
   logic [31:0]         smp_word;
   logic                smp_end;
   logic [31:0]         smp_value;
   logic [16:0]         ch_next;
   logic [31:0]         fr_next;
   logic                ch_wrap;
   logic                smp_last;
   logic [18:0]         rem_sh;
   logic                div_fit;
   logic [17:0]         rem_in;
   logic [31:0]         q_in;

   always_comb begin
      asm_eff  = cmd.clear ? 32'd0 : asm_ff;
      hdr_word = {file_byte, asm_eff[31:8]};

      priority if ((cmd.pos == wpsp_pkg::POS_RIFF) && (hdr_word != wpsp_pkg::TAG_RIFF))
         tag_err = wpsp_pkg::ERR_RIFF;
      else if ((cmd.pos == wpsp_pkg::POS_WAVE) && (hdr_word != wpsp_pkg::TAG_WAVE))
         tag_err = wpsp_pkg::ERR_WAVE;
      else if ((cmd.pos == wpsp_pkg::POS_FMT) && (hdr_word != wpsp_pkg::TAG_FMT))
         tag_err = wpsp_pkg::ERR_FMT;
      else if ((cmd.pos == wpsp_pkg::POS_DATA) && (hdr_word != wpsp_pkg::TAG_DATA))
         tag_err = wpsp_pkg::ERR_DATA;
      else
         tag_err = wpsp_pkg::ERR_NONE;

      fmt_bad = (chan_ff == 16'd0) || !wpsp_pkg::depth_ok(depth_ff);

      // valid depths are 8/16/24/32, so bits [5:3] give bytes per sample
      nbytes = depth_ff[5:3];
      unique case (nbytes)
         3'd2:    frame_bytes = {1'b0, chan_ff, 1'b0};
         3'd3:    frame_bytes = {1'b0, chan_ff, 1'b0} + {2'b00, chan_ff};
         3'd4:    frame_bytes = {chan_ff, 2'b00};
         default: frame_bytes = {2'b00, chan_ff};
      endcase

      smp_word = asm_ff | (32'(file_byte) << {bis_ff, 3'b000});
      smp_end  = ({1'b0, bis_ff} + 3'd1) >= nbytes;
      unique case (nbytes)
         3'd1:    smp_value = smp_word - 32'd128;
         3'd2:    smp_value = {{16{smp_word[15]}}, smp_word[15:0]};
         3'd3:    smp_value = {{8{smp_word[23]}}, smp_word[23:0]};
         default: smp_value = smp_word;
      endcase

      ch_next  = {1'b0, ch_cnt_ff} + 17'd1;
      fr_next  = {1'b0, fr_cnt_ff} + 32'd1;
      ch_wrap  = ch_next >= {1'b0, chan_ff};
      smp_last = (fr_next == {1'b0, frame_total_ff}) && (ch_next == {1'b0, chan_ff});

      rem_sh  = {div_rem_ff, div_q_ff[31]};
      div_fit = rem_sh >= {1'b0, div_dvsr_ff};
      rem_in  = div_fit ? 18'(rem_sh - {1'b0, div_dvsr_ff}) : rem_sh[17:0];
      q_in    = {div_q_ff[30:0], div_fit};
   end

   always_comb begin
      st.tag_err     = tag_err;
      st.fmt_bad     = fmt_bad;
      st.last        = smp_end && smp_last;
      st.div_done    = div_done_ff;
      st.frames_zero = (frame_total_ff == 31'd0);
   end

   // result item
   always_comb begin
      res_valid = (cmd.hdr && ((tag_err != wpsp_pkg::ERR_NONE) ||
                               (cmd.pos == wpsp_pkg::POS_LAST))) ||
                  (cmd.smp && smp_end);
      res.kind     = wpsp_pkg::KIND_SAMPLE;
      res.value    = 32'd0;
      res.channel  = 16'd0;
      res.frame    = 31'd0;
      res.last     = 1'b0;
      res.channels = chan_ff;
      res.rate     = rate_ff;
      res.depth    = depth_ff;
      res.err      = wpsp_pkg::ERR_NONE;
      if (cmd.smp) begin
         res.value   = smp_value;
         res.channel = ch_cnt_ff;
         res.frame   = fr_cnt_ff;
         res.last    = smp_last;
      end else if (tag_err != wpsp_pkg::ERR_NONE) begin
         res.kind = wpsp_pkg::KIND_REJECT;
         res.err  = tag_err;
      end else if (fmt_bad) begin
         res.kind = wpsp_pkg::KIND_REJECT;
         res.err  = wpsp_pkg::ERR_FORMAT;
      end else begin
         res.kind = wpsp_pkg::KIND_ACCEPT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff         <= 32'd0;
         chan_ff        <= 16'd0;
         rate_ff        <= 32'd0;
         depth_ff       <= 16'd0;
         frame_total_ff <= 31'd0;
         bis_ff         <= 2'd0;
         ch_cnt_ff      <= 16'd0;
         fr_cnt_ff      <= 31'd0;
         div_busy_ff    <= 1'b0;
         div_done_ff    <= 1'b0;
         div_cnt_ff     <= 5'd0;
         div_rem_ff     <= 18'd0;
         div_q_ff       <= 32'd0;
         div_dvsr_ff    <= 18'd1;
      end else begin
         if (cmd.clear) begin
            chan_ff        <= 16'd0;
            rate_ff        <= 32'd0;
            depth_ff       <= 16'd0;
            frame_total_ff <= 31'd0;
            bis_ff         <= 2'd0;
            ch_cnt_ff      <= 16'd0;
            fr_cnt_ff      <= 31'd0;
         end

         if (cmd.hdr) begin
            if ((tag_err == wpsp_pkg::ERR_NONE) && (cmd.pos == wpsp_pkg::POS_LAST)) begin
               asm_ff    <= 32'd0;
               bis_ff    <= 2'd0;
               ch_cnt_ff <= 16'd0;
               fr_cnt_ff <= 31'd0;
            end else begin
               asm_ff <= hdr_word;
            end
            if (tag_err == wpsp_pkg::ERR_NONE) begin
               if (cmd.pos == wpsp_pkg::POS_CHAN)  chan_ff  <= hdr_word[31:16];
               if (cmd.pos == wpsp_pkg::POS_RATE)  rate_ff  <= hdr_word;
               if (cmd.pos == wpsp_pkg::POS_DEPTH) depth_ff <= hdr_word[31:16];
            end
         end

         if (cmd.smp) begin
            if (smp_end) begin
               asm_ff <= 32'd0;
               bis_ff <= 2'd0;
               if (ch_wrap) begin
                  ch_cnt_ff <= 16'd0;
                  fr_cnt_ff <= fr_next[30:0];
               end else begin
                  ch_cnt_ff <= ch_next[15:0];
               end
            end else begin
               asm_ff <= smp_word;
               bis_ff <= bis_ff + 2'd1;
            end
         end

         // data size is the header word of the last header byte
         if (cmd.div_start) begin
            if (limit_enable) begin
               frame_total_ff <= sample_limit;
               div_done_ff    <= 1'b1;
            end else begin
               div_done_ff <= 1'b0;
               div_busy_ff <= 1'b1;
               div_cnt_ff  <= 5'd0;
               div_rem_ff  <= 18'd0;
               div_q_ff    <= hdr_word;
               div_dvsr_ff <= frame_bytes;
            end
         end else if (div_busy_ff) begin
            div_rem_ff  <= rem_in;
            div_q_ff    <= q_in;
            div_cnt_ff  <= div_cnt_ff + 5'd1;
            div_done_ff <= (div_cnt_ff == wpsp_pkg::DIV_LAST);
            if (div_cnt_ff == wpsp_pkg::DIV_LAST) begin
               div_busy_ff    <= 1'b0;
               frame_total_ff <= q_in[31] ? wpsp_pkg::FRAME_MAX : q_in[30:0];
            end
         end else begin
            div_done_ff <= 1'b0;
         end
      end
   end

endmodule

// File: src/wpsp_out_q.sv
module wpsp_out_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wpsp_pkg::rsp_type push_data,
   output logic              space,
   wpsp_rsp_if.source        rsp_bus
);

   wpsp_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              pop;
   wpsp_pkg::rsp_type head;

   always_comb begin
      pop      = rsp_bus.valid && rsp_bus.ready;
      space    = (count_ff != 2'd2);
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head     = entry_ff[rd_ptr_ff];

      rsp_bus.valid          = (count_ff != 2'd0);
      rsp_bus.item_kind      = head.kind;
      rsp_bus.sample_value   = head.value;
      rsp_bus.channel_index  = head.channel;
      rsp_bus.frame_index    = head.frame;
      rsp_bus.last_sample    = head.last;
      rsp_bus.channels_found = head.channels;
      rsp_bus.rate_found     = head.rate;
      rsp_bus.depth_found    = head.depth;
      rsp_bus.error_code     = head.err;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// File: bench/wpsp_stream_checker.sv
`timescale 1ns / 1ps
module wpsp_stream_checker (
   input  logic        clock,
   input  logic        reset,
   wpsp_req_if         req_mon,
   wpsp_rsp_if         rsp_mon,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [30:0] csr_write_data,
   output int          mismatch_total,
   output int          items_due,
   output int          samples_seen,
   output int          headers_accepted,
   output int          headers_rejected
);

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_SAMPLES,
      PARSE_DONE
   } wav_phase_type;

   // register copies
   logic        lim_en;
   logic [30:0] lim_frames;

   // per-file parse state
   wav_phase_type phase;
   logic [5:0]    hdr_pos;
   logic [15:0]   chan_cnt;
   logic [31:0]   rate_hz;
   logic [15:0]   depth_bits;
   logic [31:0]   data_bytes;
   logic [30:0]   frame_total;
   logic [31:0]   assembly;
   logic [1:0]    byte_idx;
   logic [15:0]   chan_idx;
   logic [30:0]   frame_idx;

   wpsp_pkg::rsp_type parser_items_due [$];
   int                mismatches = 0;

   task automatic clear_file_state();
      phase       = PARSE_HEADER;
      hdr_pos     = '0;
      chan_cnt    = '0;
      rate_hz     = '0;
      depth_bits  = '0;
      data_bytes  = '0;
      frame_total = '0;
      assembly    = '0;
      byte_idx    = '0;
      chan_idx    = '0;
      frame_idx   = '0;
   endtask

   task automatic push_item(wpsp_pkg::item_kind_type kind, logic [31:0] value,
                            logic [15:0] ch, logic [30:0] fr, logic is_last,
                            wpsp_pkg::error_type err);
      wpsp_pkg::rsp_type item;
      item.kind     = kind;
      item.value    = value;
      item.channel  = ch;
      item.frame    = fr;
      item.last     = is_last;
      item.channels = chan_cnt;
      item.rate     = rate_hz;
      item.depth    = depth_bits;
      item.err      = err;
      parser_items_due.push_back(item);
   endtask

   task automatic parse_header_byte(logic [7:0] b);
      wpsp_pkg::error_type err;
      logic [31:0]         frame_bytes;
      logic [31:0]         quotient;
      err      = wpsp_pkg::ERR_NONE;
      assembly = {b, assembly[31:8]};
      if (hdr_pos == wpsp_pkg::POS_RIFF && assembly != wpsp_pkg::TAG_RIFF)
         err = wpsp_pkg::ERR_RIFF;
      else if (hdr_pos == wpsp_pkg::POS_WAVE && assembly != wpsp_pkg::TAG_WAVE)
         err = wpsp_pkg::ERR_WAVE;
      else if (hdr_pos == wpsp_pkg::POS_FMT && assembly != wpsp_pkg::TAG_FMT)
         err = wpsp_pkg::ERR_FMT;
      else if (hdr_pos == wpsp_pkg::POS_DATA && assembly != wpsp_pkg::TAG_DATA)
         err = wpsp_pkg::ERR_DATA;
      else if (hdr_pos == wpsp_pkg::POS_CHAN) chan_cnt = assembly[31:16];
      else if (hdr_pos == wpsp_pkg::POS_RATE) rate_hz = assembly;
      else if (hdr_pos == wpsp_pkg::POS_DEPTH) depth_bits = assembly[31:16];
      else if (hdr_pos == wpsp_pkg::POS_LAST) data_bytes = assembly;

      if (err != wpsp_pkg::ERR_NONE) begin
         phase = PARSE_DONE;
         push_item(wpsp_pkg::KIND_REJECT, '0, '0, '0, 1'b0, err);
      end else if (hdr_pos < wpsp_pkg::POS_LAST) begin
         hdr_pos = hdr_pos + 6'd1;
      end else if (chan_cnt == 16'd0 ||
                   !(depth_bits inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
         phase = PARSE_DONE;
         push_item(wpsp_pkg::KIND_REJECT, '0, '0, '0, 1'b0, wpsp_pkg::ERR_FORMAT);
      end else begin
         if (lim_en) begin
            frame_total = lim_frames;
         end else begin
            frame_bytes = {16'd0, depth_bits / 16'd8} * {16'd0, chan_cnt};
            quotient    = data_bytes / frame_bytes;
            frame_total = (quotient > {1'b0, wpsp_pkg::FRAME_MAX}) ?
                          wpsp_pkg::FRAME_MAX : quotient[30:0];
         end
         assembly  = '0;
         byte_idx  = '0;
         chan_idx  = '0;
         frame_idx = '0;
         phase     = (frame_total == '0) ? PARSE_DONE : PARSE_SAMPLES;
         push_item(wpsp_pkg::KIND_ACCEPT, '0, '0, '0, 1'b0, wpsp_pkg::ERR_NONE);
      end
   endtask

   task automatic parse_sample_byte(logic [7:0] b);
      logic [15:0] nbytes;
      logic [31:0] value;
      logic        is_last;
      nbytes   = depth_bits / 16'd8;
      assembly = assembly | ({24'd0, b} << {byte_idx, 3'b000});
      if ({14'd0, byte_idx} + 16'd1 < nbytes) begin
         byte_idx = byte_idx + 2'd1;
      end else begin
         case (nbytes)
            16'd1:   value = assembly - 32'd128;   // offset binary
            16'd2:   value = {{16{assembly[15]}}, assembly[15:0]};
            16'd3:   value = {{8{assembly[23]}}, assembly[23:0]};
            default: value = assembly;
         endcase
         is_last = ({1'b0, frame_idx} + 32'd1 == {1'b0, frame_total}) &&
                   ({16'd0, chan_idx} + 32'd1 == {16'd0, chan_cnt});
         push_item(wpsp_pkg::KIND_SAMPLE, value, chan_idx, frame_idx, is_last,
                   wpsp_pkg::ERR_NONE);
         assembly = '0;
         byte_idx = '0;
         if ({16'd0, chan_idx} + 32'd1 >= {16'd0, chan_cnt}) begin
            chan_idx  = '0;
            frame_idx = frame_idx + 31'd1;
         end else begin
            chan_idx = chan_idx + 16'd1;
         end
         if (is_last) phase = PARSE_DONE;
      end
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
   endtask

   task automatic compare_item();
      wpsp_pkg::rsp_type want;
      if (parser_items_due.size() == 0) begin
         mismatches++;
         $error("unexpected result transfer, item_kind %0d", rsp_mon.item_kind);
      end else begin
         want = parser_items_due.pop_front();
         check_field("item_kind", want.kind, rsp_mon.item_kind);
         check_field("sample_value", want.value, rsp_mon.sample_value);
         check_field("channel_index", want.channel, rsp_mon.channel_index);
         check_field("frame_index", want.frame, rsp_mon.frame_index);
         check_field("last_sample", want.last, rsp_mon.last_sample);
         check_field("channels_found", want.channels, rsp_mon.channels_found);
         check_field("rate_found", want.rate, rsp_mon.rate_found);
         check_field("depth_found", want.depth, rsp_mon.depth_found);
         check_field("error_code", want.err, rsp_mon.error_code);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lim_en     = 1'b0;
         lim_frames = '0;
         clear_file_state();
         parser_items_due.delete();
      end else begin
         // results first: a byte taken at this edge cannot have produced one yet
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            compare_item();
            case (rsp_mon.item_kind)
               wpsp_pkg::KIND_SAMPLE: samples_seen <= samples_seen + 1;
               wpsp_pkg::KIND_ACCEPT: headers_accepted <= headers_accepted + 1;
               default:               headers_rejected <= headers_rejected + 1;
            endcase
         end
         if (csr_write_enable) begin
            if (csr_index == wpsp_pkg::CSR_LIMIT_ENABLE) lim_en = csr_write_data[0];
            else lim_frames = csr_write_data;
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.file_start) clear_file_state();
            case (phase)
               PARSE_HEADER:  parse_header_byte(req_mon.file_byte);
               PARSE_SAMPLES: parse_sample_byte(req_mon.file_byte);
               default: ;
            endcase
         end
      end
      mismatch_total <= mismatches;
      items_due      <= parser_items_due.size();
   end

endmodule

// File: bench/wav_pcm_stream_parser_top_tb.sv
`timescale 1ns / 1ps
module wav_pcm_stream_parser_top_tb;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 10;
   // covers the divider run after the last header byte, plus the output queue
   localparam int SETTLE_CYCLES = 40;
   // file bytes over the whole run, directed files included
   localparam int TOTAL_BYTES   = 1450;
   // generous bound on the length of a correct run
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = wpsp_pkg::CSR_LIMIT_ENABLE;
   logic [30:0] csr_write_data   = '0;

   wpsp_req_if req_bus ();
   wpsp_rsp_if rsp_bus ();

   // idle/stall odds in percent, changed only between phases
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   int failures;
   int items_due;
   int samples_seen;
   int headers_accepted;
   int headers_rejected;

   int cycle_count = 0;
   int bytes_sent  = 0;
   int files_sent  = 0;

   // what the registers hold, so file sizes can match the frame count
   logic        cfg_limit_en = 1'b0;
   logic [30:0] cfg_limit    = '0;

   // byte image of the file being built
   logic [7:0] file_bytes [$];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   wav_pcm_stream_parser_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wpsp_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_total   (failures),
      .items_due        (items_due),
      .samples_seen     (samples_seen),
      .headers_accepted (headers_accepted),
      .headers_rejected (headers_rejected)
   );

   // result side: ready is redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, items_due);
         $display("wav_pcm_stream_parser_top_tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- file building

   task automatic put16(logic [15:0] v);
      file_bytes.push_back(v[7:0]);
      file_bytes.push_back(v[15:8]);
   endtask

   task automatic put32(logic [31:0] v);
      for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
   endtask

   // Canonical 44-byte header. Fields the parser does not look at (chunk sizes,
   // format tag, byte rate, block align) carry random bytes.
   task automatic build_header(logic [15:0] ch, logic [31:0] rate, logic [15:0] depth,
                               logic [31:0] size);
      file_bytes.delete();
      put32(wpsp_pkg::TAG_RIFF);
      put32($urandom);
      put32(wpsp_pkg::TAG_WAVE);
      put32(wpsp_pkg::TAG_FMT);
      put32($urandom);
      put16(16'($urandom));
      put16(ch);            // bytes 22..23
      put32(rate);          // bytes 24..27
      put32($urandom);
      put16(16'($urandom));
      put16(depth);         // bytes 34..35
      put32(wpsp_pkg::TAG_DATA);      // bytes 36..39
      put32(size);          // bytes 40..43
   endtask

   // sample data leans on the sign and offset boundaries
   task automatic add_sample_bytes(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0:       file_bytes.push_back(8'h00);
            1:       file_bytes.push_back(8'h80);
            2:       file_bytes.push_back(8'hFF);
            3:       file_bytes.push_back(8'h7F);
            default: file_bytes.push_back(8'($urandom));
         endcase
      end
   endtask

   // ---------------------------------------------------------------- driving

   // One req transfer. Data changes on the falling edge; ready is looked at on
   // the rising edge, where the transfer happens.
   task automatic send_byte(logic [7:0] value, logic start);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.file_byte  <= value;
      req_bus.file_start <= start;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Sends the first count bytes of the image, then junk bytes that a finished
   // or rejected file should ignore.
   task automatic send_file(int count, logic with_start, int junk);
      for (int i = 0; i < count; i++) send_byte(file_bytes[i], (i == 0) ? with_start : 1'b0);
      for (int i = 0; i < junk; i++) send_byte(8'($urandom), 1'b0);
      bytes_sent += count + junk;
      files_sent++;
   endtask

   // Sender holds off until every predicted result has been transferred.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (items_due != 0);
   endtask

   // Registers change only with the parser quiet; the extra cycles cover a
   // header whose divide is still running with no result pending.
   task automatic settle_and_program(logic en, logic [30:0] limit);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= wpsp_pkg::CSR_LIMIT_ENABLE;
      csr_write_data   <= {30'd0, en};
      @(negedge clock);
      csr_index        <= wpsp_pkg::CSR_SAMPLE_LIMIT;
      csr_write_data   <= limit;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_limit_en = en;
      cfg_limit    = limit;
   endtask

   // ---------------------------------------------------------------- file kinds

   // Well-formed file with random content. Mostly small channel counts and a
   // few frames; now and then a huge channel count or a truncated data chunk
   // that the next file_start cuts off.
   task automatic send_good_file();
      int          nb;
      int          ch;
      int          fbytes;
      int          body;
      logic [31:0] size;
      nb = $urandom_range(1, 4);
      case ($urandom_range(19))
         0:          ch = $urandom_range(9, 65535);
         1, 2, 3, 4: ch = $urandom_range(4, 8);
         default:    ch = $urandom_range(1, 3);
      endcase
      fbytes = nb * ch;
      if (cfg_limit_en) begin
         size = $urandom;
         body = int'(cfg_limit) * fbytes;
      end else if (ch > 8) begin
         size = $urandom;
         body = 0;
      end else begin
         body = $urandom_range(0, 6) * fbytes;
         size = 32'(body + $urandom_range(0, fbytes - 1));   // remainder is dropped
      end
      if (ch > 8) body = $urandom_range(1, 24);
      else if ($urandom_range(7) == 0) body = $urandom_range(0, body);
      build_header(16'(ch), $urandom, 16'(8 * nb), size);
      add_sample_bytes(body);
      send_file(file_bytes.size(), 1'b1, ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0);
   endtask

   // One bit flipped somewhere in the tag that ends at tag_last; the file is
   // cut shortly after, since the rest is ignored anyway.
   task automatic send_broken_tag(int tag_last);
      int hit;
      build_header(16'($urandom_range(1, 4)), $urandom, 16'd16, 32'($urandom_range(0, 64)));
      hit = tag_last - $urandom_range(0, 3);
      file_bytes[hit] = file_bytes[hit] ^ (8'd1 << $urandom_range(0, 7));
      send_file(tag_last + 1, 1'b1, $urandom_range(0, 3));
   endtask

   // Tags intact, but zero channels or an unsupported bit depth.
   task automatic send_bad_format();
      logic [15:0] ch;
      logic [15:0] depth;
      if ($urandom_range(2) == 0) begin
         ch    = '0;
         depth = ($urandom_range(1) == 0) ? 16'(8 * $urandom_range(1, 4)) : 16'($urandom);
      end else begin
         ch = 16'($urandom_range(1, 65535));
         case ($urandom_range(3))
            0:       depth = 16'($urandom_range(0, 40));
            1:       depth = 16'($urandom);
            2:       depth = 16'hFFFF;
            default: depth = 16'd0;
         endcase
         if (depth inside {16'd8, 16'd16, 16'd24, 16'd32}) depth = depth + 16'd1;
      end
      build_header(ch, $urandom, depth, $urandom);
      send_file(wpsp_pkg::HEADER_BYTES, 1'b1, $urandom_range(0, 2));
   endtask

   // Random bytes with file_start set here and there.
   task automatic send_noise();
      int n;
      n = $urandom_range(3, 12);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), (i == 0) || ($urandom_range(7) == 0));
      bytes_sent += n;
      files_sent++;
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin
      int directed_bytes;
      int pick;

      req_bus.valid      = 1'b0;
      req_bus.file_byte  = '0;
      req_bus.file_start = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---

      // first file has no file_start: parsing begins at byte 0 anyway;
      // 16-bit stereo with zero, max, min and -1
      build_header(16'd2, 32'd44100, 16'd16, 32'd8);
      put16(16'h0000);
      put16(16'h7FFF);
      put16(16'h8000);
      put16(16'hFFFF);
      send_file(file_bytes.size(), 1'b0, 0);

      // 8-bit offset binary: 0x00, 0x80, 0xFF, 0x7F
      build_header(16'd1, 32'd0, 16'd8, 32'd4);
      put32(32'h7FFF_8000);
      send_file(file_bytes.size(), 1'b1, 2);

      // 24-bit min and max
      build_header(16'd1, 32'd96000, 16'd24, 32'd6);
      put16(16'h0000);
      put16(16'hFF80);
      put16(16'h7FFF);
      send_file(file_bytes.size(), 1'b1, 0);

      // 32-bit min and max, largest rate
      build_header(16'd1, 32'hFFFF_FFFF, 16'd32, 32'd8);
      put32(32'h8000_0000);
      put32(32'h7FFF_FFFF);
      send_file(file_bytes.size(), 1'b1, 0);

      // each tag wrong once; bytes after the rejection are ignored
      send_broken_tag(int'(wpsp_pkg::POS_RIFF));
      send_broken_tag(int'(wpsp_pkg::POS_WAVE));
      send_broken_tag(int'(wpsp_pkg::POS_FMT));
      send_broken_tag(int'(wpsp_pkg::POS_DATA));

      // unsupported format: zero channels, 12-bit depth, all-ones depth
      build_header(16'd0, 32'd8000, 16'd16, 32'd100);
      send_file(wpsp_pkg::HEADER_BYTES, 1'b1, 2);
      build_header(16'd1, 32'd8000, 16'd12, 32'd100);
      send_file(wpsp_pkg::HEADER_BYTES, 1'b1, 0);
      build_header(16'hFFFF, 32'd8000, 16'hFFFF, 32'd100);
      send_file(wpsp_pkg::HEADER_BYTES, 1'b1, 0);

      // data smaller than one frame: accepted, no samples, trailer ignored
      build_header(16'd1, 32'd48000, 16'd32, 32'd3);
      send_file(wpsp_pkg::HEADER_BYTES, 1'b1, 2);

      // frame count saturates; restart in the middle of the data chunk
      build_header(16'd1, 32'd22050, 16'd8, 32'hFFFF_FFFF);
      add_sample_bytes(3);
      send_file(file_bytes.size(), 1'b1, 0);

      // header cut short by a new file_start
      build_header(16'd1, 32'd8000, 16'd8, 32'd1);
      send_file(20, 1'b1, 0);

      // frame limit: zero, largest, and a small one ending on the last channel
      settle_and_program(1'b1, 31'd0);
      build_header(16'd2, 32'd44100, 16'd16, 32'hFFFF_FFFF);
      send_file(wpsp_pkg::HEADER_BYTES, 1'b1, 3);

      settle_and_program(1'b1, wpsp_pkg::FRAME_MAX);
      build_header(16'd1, 32'd44100, 16'd8, 32'd0);
      add_sample_bytes(2);
      send_file(file_bytes.size(), 1'b1, 0);

      settle_and_program(1'b1, 31'd2);
      build_header(16'd3, 32'd44100, 16'd16, 32'd0);
      add_sample_bytes(12);
      send_file(file_bytes.size(), 1'b1, 2);

      directed_bytes = bytes_sent;

      // --- random, four handshake phases ---
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               settle_and_program(1'b0, wpsp_pkg::FRAME_MAX);
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               settle_and_program(1'b1, 31'($urandom_range(1, 5)));
               sender_idle_pct    = 47;
               receiver_stall_pct = 0;
            end
            2: begin
               settle_and_program(1'b0, 31'($urandom));
               sender_idle_pct    = 0;
               receiver_stall_pct = 47;
            end
            default: begin
               settle_and_program(1'b1, 31'($urandom_range(0, 4)));
               sender_idle_pct    = 20;
               receiver_stall_pct = 20;
            end
         endcase

         while (bytes_sent - directed_bytes < (TOTAL_BYTES - directed_bytes) * (p + 1) / 4)
         begin
            if ($urandom_range(9) == 0) wait_drained();
            pick = $urandom_range(99);
            if (pick < 65) begin
               send_good_file();
            end else if (pick < 75) begin
               case ($urandom_range(3))
                  0:       send_broken_tag(int'(wpsp_pkg::POS_RIFF));
                  1:       send_broken_tag(int'(wpsp_pkg::POS_WAVE));
                  2:       send_broken_tag(int'(wpsp_pkg::POS_FMT));
                  default: send_broken_tag(int'(wpsp_pkg::POS_DATA));
               endcase
            end else if (pick < 85) begin
               send_bad_format();
            end else if (pick < 93) begin
               build_header(16'($urandom_range(1, 4)), $urandom,
                            16'(8 * $urandom_range(1, 4)), $urandom);
               send_file($urandom_range(1, wpsp_pkg::HEADER_BYTES - 1), 1'b1, 0);
            end else begin
               send_noise();
            end
         end
      end

      // drain, then give a trailing header divide time to show up
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d files, %0d file bytes: directed tag, format, depth,", files_sent,
               bytes_sent);
      $display("limit and restart cases, then four phases; %0d samples, %0d/%0d headers ok/bad.",
               samples_seen, headers_accepted, headers_rejected);
      if (failures == 0 && items_due == 0) begin
         $display("wav_pcm_stream_parser_top_tb: PASS");
      end else begin
         $display("wav_pcm_stream_parser_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/wpsp_pkg.sv
src/wpsp_if.sv
src/wpsp_ctrl.sv
src/wpsp_datapath.sv
src/wpsp_out_q.sv
src/wav_pcm_stream_parser_top.sv
bench/wpsp_stream_checker.sv
bench/wav_pcm_stream_parser_top_tb.sv
